// ===== sv/postings_phrase_match_unit_assert.svh =====
// Assertion macros used by the checker file of the phrase match unit.
// No dependencies.
`ifndef POSTINGS_PHRASE_MATCH_UNIT_ASSERT_SVH
`define POSTINGS_PHRASE_MATCH_UNIT_ASSERT_SVH

// Implication checked on every rising edge outside reset.
`define PPM_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication checked on every rising edge outside reset.
`define PPM_ASSERT_NXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== sv/ppm_pkg.sv =====
// Package of the phrase match unit: payload structs, codes, sequencer states.
// No dependencies.
package ppm_pkg;

  typedef enum logic [2:0] {
    MODE_CLEAR = 3'd0,
    MODE_APP_A = 3'd1,
    MODE_APP_B = 3'd2,
    MODE_OPEN  = 3'd3,
    MODE_NEXT  = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_END   = 3'd1,
    ST_TRUNC = 3'd2,
    ST_OVER  = 3'd3,
    ST_FULL  = 3'd4
  } status_e;

  localparam logic CFG_CAP_A = 1'b0;
  localparam logic CFG_CAP_B = 1'b1;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] word;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] page_id;
    logic [8:0]  match_count;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_OPEN_RD,     // latch word 0 (total) of A and B
    S_OPEN_RDB,    // never entered
    S_OPEN_WB,     // never entered
    S_DEC_START,   // check end and header room
    S_DEC_H0,      // delta arrives
    S_DEC_H1,      // frequency arrives
    S_DEC_POS,     // position deltas stream in
    S_DEC_DONE,
    S_MERGE,
    S_ADJ_RD,
    S_ADJ_CMP,
    S_RESP
  } state_e;

endpackage

// ===== sv/ppm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ppm_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== sv/postings_phrase_match_unit.sv =====
// Phrase match unit over two delta-coded postings buffers.
// One input channel carries a mode and a word; one output channel carries
// status, page id and match count; one result per accepted item.
// A config channel writes pos_cap_a (index 0) and pos_cap_b (index 1).
// Append and clear load the result register at the accepting edge. Open and
// next run a sequencer that streams the buffers through their RAM read ports,
// one word a cycle: a document is decoded as header words, then positions,
// and the adjacency count takes a read and a compare state per position
// step of the shared compare unit.
// The block takes no item while a result waits or work is under way.
// A stalled receiver simply holds the result; nothing is lost.
// Reset clears lengths, valid flags, sticky error and caps to 256; buffer
// contents are undefined until written and no clearing pass is needed.
// Depends on ppm_pkg and ppm_ram.
module postings_phrase_match_unit #(
  parameter int BUF_WORDS     = 4096,
  parameter int MAX_POSITIONS = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ppm_pkg::in_item_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ppm_pkg::out_item_t   out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_index_i,
  input  logic [8:0]           cfg_data_i
);
  localparam int AW = $clog2(BUF_WORDS);
  localparam int LW = AW + 1;
  localparam int PW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
  localparam int FW = $clog2(MAX_POSITIONS + 1);

  ppm_pkg::state_e state_q, state_d;

  logic [8:0]  cap_a_q, cap_b_q;
  logic [LW-1:0] len_a_q, len_b_q, len_a_d, len_b_d;
  logic [LW-1:0] ptr_q [2];
  logic [LW-1:0] ptr_d [2];
  logic [31:0] total_q [2];
  logic [31:0] total_d [2];
  logic [31:0] done_q [2];
  logic [31:0] done_d [2];
  logic [31:0] page_q [2];
  logic [31:0] page_d [2];
  logic [FW-1:0] freq_q [2];
  logic [FW-1:0] freq_d [2];
  logic [1:0]  vld_q, vld_d;
  logic [2:0]  sticky_q, sticky_d;
  logic        is_open_q, is_open_d;  // open decodes A then B
  logic        sel_q, sel_d;          // stream being decoded
  logic [31:0] delta_q, delta_d, acc_q, acc_d;
  logic [FW-1:0] cnt_q, cnt_d;       // positions written so far
  logic [FW-1:0] ia_q, ia_d, ib_q, ib_d;
  logic [8:0]  n_q, n_d;
  logic [31:0] pg_q, pg_d;
  logic        match_q, match_d;     // pending match after advance of both
  logic        pend_b_q, pend_b_d;   // B still to advance
  ppm_pkg::out_item_t res_q, res_d;
  logic        out_v_q, out_v_d;

  // buffer RAMs
  logic          wb_we [2];
  logic [AW-1:0] wb_ra [2];
  logic [31:0]   wb_rd [2];
  // position RAMs
  logic          ps_we [2];
  logic [PW-1:0] ps_wa [2];
  logic [PW-1:0] ps_ra [2];
  logic [31:0]   ps_rd [2];

  for (genvar s = 0; s < 2; s++) begin : g_mem
    ppm_ram #(.Width(32), .Depth(BUF_WORDS)) u_words (
      .clk_i, .we_i(wb_we[s]),
      .waddr_i(s == 0 ? len_a_q[AW-1:0] : len_b_q[AW-1:0]),
      .wdata_i(in_data_i.word), .raddr_i(wb_ra[s]), .rdata_o(wb_rd[s]));
    ppm_ram #(.Width(32), .Depth(MAX_POSITIONS)) u_pos (
      .clk_i, .we_i(ps_we[s]), .waddr_i(ps_wa[s]), .wdata_i(acc_d),
      .raddr_i(ps_ra[s]), .rdata_o(ps_rd[s]));
  end

  logic in_acc;
  assign in_ready_o  = (state_q == ppm_pkg::S_IDLE) && !out_v_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_v_q;
  assign out_data_o  = res_q;

  // shared decode signals for the stream in sel_q
  logic [LW-1:0] len_s, rem_s;
  logic [8:0]    cap_s;
  logic [31:0]   hdr_f;
  assign len_s = sel_q ? len_b_q : len_a_q;
  assign cap_s = sel_q ? cap_b_q : cap_a_q;
  assign rem_s = len_s - ptr_q[sel_q];
  assign hdr_f = wb_rd[sel_q];

  // adjacency compare unit
  logic [31:0] va;
  assign va = ps_rd[0] + 32'd1;

  always_comb begin
    state_d = state_q;
    len_a_d = len_a_q; len_b_d = len_b_q;
    ptr_d = ptr_q; total_d = total_q; done_d = done_q;
    page_d = page_q; freq_d = freq_q;
    vld_d = vld_q; sticky_d = sticky_q;
    is_open_d = is_open_q; sel_d = sel_q;
    delta_d = delta_q; acc_d = acc_q; cnt_d = cnt_q;
    ia_d = ia_q; ib_d = ib_q; n_d = n_q; pg_d = pg_q;
    match_d = match_q; pend_b_d = pend_b_q;
    res_d = res_q; out_v_d = out_v_q;
    for (int s = 0; s < 2; s++) begin
      wb_we[s] = 1'b0;
      wb_ra[s] = ptr_q[s][AW-1:0];
      ps_we[s] = 1'b0;
      ps_ra[s] = '0;
    end
    ps_ra[0] = ia_q[PW-1:0];
    ps_ra[1] = ib_q[PW-1:0];

    if (out_v_q && out_ready_i) begin
      out_v_d = 1'b0;
    end

    case (state_q)
      ppm_pkg::S_IDLE: begin
        if (in_acc) begin
          res_d = '0;
          case (in_data_i.mode)
            ppm_pkg::MODE_CLEAR: begin
              len_a_d = '0; len_b_d = '0; vld_d = '0; sticky_d = ppm_pkg::ST_OK;
              out_v_d = 1'b1;
            end
            ppm_pkg::MODE_APP_A: begin
              if (len_a_q < LW'(BUF_WORDS)) begin
                wb_we[0] = 1'b1; len_a_d = len_a_q + 1'b1;
              end else begin
                res_d.status = ppm_pkg::ST_FULL;
              end
              out_v_d = 1'b1;
            end
            ppm_pkg::MODE_APP_B: begin
              if (len_b_q < LW'(BUF_WORDS)) begin
                wb_we[1] = 1'b1; len_b_d = len_b_q + 1'b1;
              end else begin
                res_d.status = ppm_pkg::ST_FULL;
              end
              out_v_d = 1'b1;
            end
            ppm_pkg::MODE_OPEN: begin
              sticky_d = ppm_pkg::ST_OK; vld_d = '0;
              if (len_a_q == '0 || len_b_q == '0) begin
                sticky_d = ppm_pkg::ST_TRUNC;
                res_d.status = ppm_pkg::ST_TRUNC;
                out_v_d = 1'b1;
              end else begin
                wb_ra[0] = '0; wb_ra[1] = '0;
                state_d = ppm_pkg::S_OPEN_RD;
              end
            end
            ppm_pkg::MODE_NEXT: begin
              if (sticky_q != ppm_pkg::ST_OK) begin
                res_d.status = sticky_q; out_v_d = 1'b1;
              end else begin
                state_d = ppm_pkg::S_MERGE;
              end
            end
            default: out_v_d = 1'b1;
          endcase
        end
      end
      ppm_pkg::S_OPEN_RD: begin
        // both word-0 reads issued in idle; data present now
        total_d[0] = wb_rd[0]; total_d[1] = wb_rd[1];
        for (int s = 0; s < 2; s++) begin
          ptr_d[s] = LW'(1); done_d[s] = '0; page_d[s] = '0; freq_d[s] = '0;
        end
        is_open_d = 1'b1; sel_d = 1'b0;
        state_d = ppm_pkg::S_DEC_START;
      end
      ppm_pkg::S_DEC_START: begin
        if (done_q[sel_q] >= total_q[sel_q]) begin
          vld_d[sel_q] = 1'b0;
          state_d = ppm_pkg::S_DEC_DONE;
        end else if (ptr_q[sel_q] > len_s || rem_s < LW'(2)) begin
          state_d = ppm_pkg::S_RESP;
          sticky_d = ppm_pkg::ST_TRUNC;
        end else begin
          wb_ra[sel_q] = ptr_q[sel_q][AW-1:0];
          ptr_d[sel_q] = ptr_q[sel_q] + 1'b1;
          state_d = ppm_pkg::S_DEC_H0;
        end
      end
      ppm_pkg::S_DEC_H0: begin
        delta_d = wb_rd[sel_q];
        wb_ra[sel_q] = ptr_q[sel_q][AW-1:0];
        ptr_d[sel_q] = ptr_q[sel_q] + 1'b1;
        state_d = ppm_pkg::S_DEC_H1;
      end
      ppm_pkg::S_DEC_H1: begin
        if (hdr_f > {23'd0, cap_s} || hdr_f > 32'(MAX_POSITIONS)) begin
          sticky_d = ppm_pkg::ST_OVER; state_d = ppm_pkg::S_RESP;
        end else if ({{(32-LW){1'b0}}, rem_s} < hdr_f) begin
          sticky_d = ppm_pkg::ST_TRUNC; state_d = ppm_pkg::S_RESP;
        end else begin
          page_d[sel_q] = page_q[sel_q] + delta_q;
          freq_d[sel_q] = FW'(hdr_f);
          acc_d = '0; cnt_d = '0;
          wb_ra[sel_q] = ptr_q[sel_q][AW-1:0];
          state_d = ppm_pkg::S_DEC_POS;
        end
      end
      ppm_pkg::S_DEC_POS: begin
        if (cnt_q == freq_q[sel_q]) begin
          done_d[sel_q] = done_q[sel_q] + 32'd1;
          vld_d[sel_q] = 1'b1;
          state_d = ppm_pkg::S_DEC_DONE;
        end else begin
          acc_d = acc_q + wb_rd[sel_q];
          ps_we[sel_q] = 1'b1;
          cnt_d = cnt_q + 1'b1;
          ptr_d[sel_q] = ptr_q[sel_q] + 1'b1;
          wb_ra[sel_q] = ptr_d[sel_q][AW-1:0];
        end
      end
      ppm_pkg::S_DEC_DONE: begin
        if (is_open_q) begin
          if (!sel_q) begin
            sel_d = 1'b1; state_d = ppm_pkg::S_DEC_START;
          end else begin
            is_open_d = 1'b0; state_d = ppm_pkg::S_RESP;
          end
        end else if (pend_b_q) begin
          pend_b_d = 1'b0; sel_d = 1'b1; state_d = ppm_pkg::S_DEC_START;
        end else begin
          state_d = ppm_pkg::S_MERGE;
        end
      end
      ppm_pkg::S_MERGE: begin
        if (match_q) begin
          match_d = 1'b0;
          res_d.page_id = pg_q; res_d.match_count = n_q;
          state_d = ppm_pkg::S_RESP;
        end else if (!(vld_q[0] && vld_q[1])) begin
          res_d.status = ppm_pkg::ST_END; out_v_d = 1'b1;
          state_d = ppm_pkg::S_IDLE;
        end else if (page_q[0] == page_q[1]) begin
          pg_d = page_q[0]; n_d = '0; ia_d = '0; ib_d = '0;
          state_d = ppm_pkg::S_ADJ_RD;
        end else begin
          sel_d = (page_q[0] < page_q[1]) ? 1'b0 : 1'b1;
          state_d = ppm_pkg::S_DEC_START;
        end
      end
      ppm_pkg::S_ADJ_RD: begin
        if (ia_q == freq_q[0] || ib_q == freq_q[1]) begin
          match_d = (n_q != '0);
          pend_b_d = 1'b1; sel_d = 1'b0;
          state_d = ppm_pkg::S_DEC_START;
        end else begin
          state_d = ppm_pkg::S_ADJ_CMP;
        end
      end
      ppm_pkg::S_ADJ_CMP: begin
        if (va == ps_rd[1]) begin
          n_d = n_q + 9'd1; ia_d = ia_q + 1'b1; ib_d = ib_q + 1'b1;
        end else if (va < ps_rd[1]) begin
          ia_d = ia_q + 1'b1;
        end else begin
          ib_d = ib_q + 1'b1;
        end
        state_d = ppm_pkg::S_ADJ_RD;
      end
      ppm_pkg::S_RESP: begin
        if (sticky_q != ppm_pkg::ST_OK) begin
          vld_d = '0; res_d = '0; res_d.status = sticky_q;
          match_d = 1'b0; pend_b_d = 1'b0; is_open_d = 1'b0;
        end
        out_v_d = 1'b1;
        state_d = ppm_pkg::S_IDLE;
      end
      default: state_d = ppm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ppm_pkg::S_IDLE;
      cap_a_q <= 9'd256; cap_b_q <= 9'd256;
      len_a_q <= '0; len_b_q <= '0;
      for (int s = 0; s < 2; s++) begin
        ptr_q[s] <= LW'(1); total_q[s] <= '0; done_q[s] <= '0;
        page_q[s] <= '0; freq_q[s] <= '0;
      end
      vld_q <= '0; sticky_q <= ppm_pkg::ST_OK;
      is_open_q <= 1'b0; sel_q <= 1'b0;
      match_q <= 1'b0; pend_b_q <= 1'b0; out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == ppm_pkg::CFG_CAP_A) cap_a_q <= cfg_data_i;
        else cap_b_q <= cfg_data_i;
      end
      len_a_q <= len_a_d; len_b_q <= len_b_d;
      ptr_q <= ptr_d; total_q <= total_d; done_q <= done_d;
      page_q <= page_d; freq_q <= freq_d;
      vld_q <= vld_d; sticky_q <= sticky_d;
      is_open_q <= is_open_d; sel_q <= sel_d;
      match_q <= match_d; pend_b_q <= pend_b_d; out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    delta_q <= delta_d; acc_q <= acc_d; cnt_q <= cnt_d;
    ia_q <= ia_d; ib_q <= ib_d; n_q <= n_d; pg_q <= pg_d;
    res_q <= res_d;
  end

  for (genvar s = 0; s < 2; s++) begin : g_pw
    assign ps_wa[s] = cnt_q[PW-1:0];
  end

endmodule

// ===== sv/ppm_checker.sv =====
// Port-level checker for the phrase match unit, bound to the top level.
// Depends on ppm_pkg and postings_phrase_match_unit_assert.svh.
`include "postings_phrase_match_unit_assert.svh"
module ppm_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input ppm_pkg::out_item_t out_data_o
);
  `PPM_ASSERT_IMP(a_one_at_a_time, clk_i, rst_ni, out_valid_o, !in_ready_o, "ready while result pending")
  `PPM_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result dropped")
  `PPM_ASSERT_IMP(a_page_zero, clk_i, rst_ni, out_valid_o && out_data_o.status != ppm_pkg::ST_OK, out_data_o.page_id == '0 && out_data_o.match_count == '0, "page on non-match")
  `PPM_ASSERT_NXT(a_take_busy, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "ready after transfer")
endmodule

bind postings_phrase_match_unit ppm_checker u_ppm_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .out_data_o
);
